FILE: hdl/rac_pkg.sv
// ============================================================================
// rac_pkg: shared types and codes for the region access checker
// Beat payloads, operation and status codes, and region cell control.
// ============================================================================
package rac_pkg;

  // Item operations
  localparam logic [2:0] MODE_CHECK     = 3'd0;
  localparam logic [2:0] MODE_ADD       = 3'd1;
  localparam logic [2:0] MODE_REMOVE    = 3'd2;
  localparam logic [2:0] MODE_ISOLATE   = 3'd3;
  localparam logic [2:0] MODE_READ_ONLY = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BOUNDS = 3'd1;
  localparam logic [2:0] ST_ALIGN  = 3'd2;
  localparam logic [2:0] ST_PROT   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_NOBASE = 3'd5;

  // Permission bit positions
  localparam int PERM_R  = 0;
  localparam int PERM_W  = 1;
  localparam int PERM_X  = 2;
  localparam int PERM_RO = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MEMORY_SIZE  = 2'd0;
  localparam logic [1:0] CFG_STRICT_ALIGN = 2'd1;
  localparam logic [1:0] CFG_MEM_READY    = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] address;
    logic        write_access;
    logic [1:0]  size_log2;
    logic [63:0] region_length;
    logic [3:0]  region_flags;
  } rac_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       region_hit;
    logic [2:0] region_index;
  } rac_out_t;

  // Per-cycle commands from the controller to every cell
  typedef struct packed {
    logic capture;
    logic eval;
    logic add_en;
    logic remove_en;
    logic isolate;
    logic read_only;
  } rac_cell_ctl_t;

  // Per-cell check outcome, valid while the result is formed
  typedef struct packed {
    logic first_hit;
    logic prot_fail;
    logic fit_fail;
  } rac_cell_sts_t;

endpackage

FILE: hdl/region_access_checker.sv
// ============================================================================
// region_access_checker: guest access check against a region table
// Alignment, bounds and region permission checks plus region table upkeep.
// ============================================================================
// Usage:
//   in_valid/in_stall carries one item (rac_in_t): a check, an add, a remove,
//   an isolate or an all read-only operation. out_valid/out_stall returns one
//   rac_out_t result per item, in order. cfg_valid/cfg_ready writes the
//   memory size, strict alignment and memory ready registers; cfg_ready is
//   always high, and the user must make writes only while the block is
//   idle; the block itself does not enforce this. The table lives in a
//   chain of MAX_REGIONS cells, and one item walks a capture stage, a
//   compare stage (S_EVAL) and a resolve stage (S_FIN), where its result
//   is written to the output register, before the next is taken.
//   A result waiting under out_stall stays in the output register; a new
//   item is still taken and runs up to its resolve stage, where it waits
//   until the output register is free.
//   Reset (rst_n low, synchronous) empties the table, zeroes the
//   configuration registers and drops out_valid.
// ============================================================================
module region_access_checker import rac_pkg::*; #(
  parameter int MAX_REGIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rac_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rac_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  rac_in_t        item_r;
  rac_out_t       out_data_r, res;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    memory_size_r;
  logic           strict_align_r, mem_ready_r;
  logic           mis_r, oob_r;
  logic           in_accept, fin_go;
  logic [3:0]     acc_len;
  logic [2:0]     align_mask;
  logic [64:0]    end_sum;
  rac_cell_ctl_t  ctl;

  logic [MAX_REGIONS-1:0] occ, prev_occ, nb_occ;
  logic [MAX_REGIONS-1:0] first_v, prot_v, fit_v;
  logic [MAX_REGIONS:0]   seen_hit, seen_eq;
  logic [63:0]            base_a [MAX_REGIONS];
  logic [63:0]            size_a [MAX_REGIONS];
  logic [3:0]             perm_a [MAX_REGIONS];
  logic [63:0]            nb_base [MAX_REGIONS];
  logic [63:0]            nb_size [MAX_REGIONS];
  logic [3:0]             nb_perm [MAX_REGIONS];
  rac_cell_sts_t          sts_a [MAX_REGIONS];

  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W+2:0] idx_ext;
  logic             any_prot, any_fit;

  // Handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign fin_go    = (state_r == S_FIN) & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_size_r  <= '0;
      strict_align_r <= 1'b0;
      mem_ready_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MEMORY_SIZE:  memory_size_r  <= cfg_data;
        CFG_STRICT_ALIGN: strict_align_r <= cfg_data[0];
        CFG_MEM_READY:    mem_ready_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // Alignment and overall bounds, in parallel with the cell compare stage
  assign acc_len    = 4'b0001 << item_r.size_log2;
  assign align_mask = 3'(acc_len - 4'd1);
  assign end_sum    = {1'b0, item_r.address} + {61'b0, acc_len};

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      mis_r <= strict_align_r & (item_r.size_log2 != 2'd0)
               & (|(item_r.address[2:0] & align_mask));
      oob_r <= ~mem_ready_r | end_sum[64] | (end_sum[63:0] > memory_size_r);
    end
  end

  // Cell commands
  always_comb begin
    ctl           = '0;
    ctl.capture   = in_accept;
    ctl.eval      = (state_r == S_EVAL);
    ctl.add_en    = fin_go & (item_r.mode == MODE_ADD) & (item_r.region_length != '0);
    ctl.remove_en = fin_go & (item_r.mode == MODE_REMOVE);
    ctl.isolate   = fin_go & (item_r.mode == MODE_ISOLATE);
    ctl.read_only = fin_go & (item_r.mode == MODE_READ_ONLY);
  end

  // Chain of region cells
  assign seen_hit[0] = 1'b0;
  assign seen_eq[0]  = 1'b0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_occ[i] = 1'b1;
    end else begin : g_body
      assign prev_occ[i] = occ[i-1];
    end

    if (i == MAX_REGIONS - 1) begin : g_tail
      assign nb_occ[i]  = 1'b0;
      assign nb_base[i] = '0;
      assign nb_size[i] = '0;
      assign nb_perm[i] = '0;
    end else begin : g_link
      assign nb_occ[i]  = occ[i+1];
      assign nb_base[i] = base_a[i+1];
      assign nb_size[i] = size_a[i+1];
      assign nb_perm[i] = perm_a[i+1];
    end

    rac_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .cap_addr     (in_data.address),
      .item_addr    (item_r.address),
      .item_len     (item_r.region_length),
      .item_flags   (item_r.region_flags),
      .item_write   (item_r.write_access),
      .acc_len      (acc_len),
      .prev_occ     (prev_occ[i]),
      .seen_hit_in  (seen_hit[i]),
      .seen_eq_in   (seen_eq[i]),
      .nb_occ       (nb_occ[i]),
      .nb_base      (nb_base[i]),
      .nb_size      (nb_size[i]),
      .nb_perm      (nb_perm[i]),
      .occ          (occ[i]),
      .base         (base_a[i]),
      .size         (size_a[i]),
      .perm         (perm_a[i]),
      .seen_hit_out (seen_hit[i+1]),
      .seen_eq_out  (seen_eq[i+1]),
      .sts          (sts_a[i])
    );

    assign first_v[i] = sts_a[i].first_hit;
    assign prot_v[i]  = sts_a[i].prot_fail;
    assign fit_v[i]   = sts_a[i].fit_fail;
  end

  // Matched region index; at most one cell flags first hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (first_v[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign idx_ext  = {3'b000, hit_idx};
  assign any_prot = |(first_v & prot_v);
  assign any_fit  = |(first_v & fit_v);

  // Result
  always_comb begin
    res = '0;
    case (item_r.mode)
      MODE_CHECK: begin
        if (mis_r) begin
          res.status = ST_ALIGN;
        end else if (oob_r) begin
          res.status = ST_BOUNDS;
        end else if (seen_hit[MAX_REGIONS]) begin
          res.region_hit   = 1'b1;
          res.region_index = idx_ext[2:0];
          if (any_prot) begin
            res.status = ST_PROT;
          end else if (any_fit) begin
            res.status = ST_BOUNDS;
          end
        end
      end
      MODE_ADD: begin
        if (item_r.region_length == '0) begin
          res.status = ST_BOUNDS;
        end else if (occ[MAX_REGIONS-1]) begin
          res.status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (!seen_eq[MAX_REGIONS]) begin
          res.status = ST_NOBASE;
        end
      end
      default: res.status = ST_OK;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= res;
    end
  end

  // Checks
  a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (occ & ~prev_occ) == '0)
    else $error("region table occupancy has a hole");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && res.status == ST_FULL) |-> occ[MAX_REGIONS-1])
    else $error("table full reported with a free slot");

  a_hit_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && res.region_hit) |-> (item_r.mode == MODE_CHECK))
    else $error("region hit reported on a table operation");

  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result beat without a resolve stage");

endmodule

FILE: hdl/rac_cell.sv
// ============================================================================
// rac_cell: one region slot of the checker chain
// Holds a region, tests an access against it, and passes its contents to the
// lower neighbor so that a removal shifts the table down by one slot.
// ============================================================================
module rac_cell import rac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  rac_cell_ctl_t ctl,
  input  logic [63:0]   cap_addr,
  input  logic [63:0]   item_addr,
  input  logic [63:0]   item_len,
  input  logic [3:0]    item_flags,
  input  logic          item_write,
  input  logic [3:0]    acc_len,
  input  logic          prev_occ,
  input  logic          seen_hit_in,
  input  logic          seen_eq_in,
  input  logic          nb_occ,
  input  logic [63:0]   nb_base,
  input  logic [63:0]   nb_size,
  input  logic [3:0]    nb_perm,
  output logic          occ,
  output logic [63:0]   base,
  output logic [63:0]   size,
  output logic [3:0]    perm,
  output logic          seen_hit_out,
  output logic          seen_eq_out,
  output rac_cell_sts_t sts
);

  logic        occ_r;
  logic [63:0] base_r, size_r;
  logic [3:0]  perm_r;
  logic        ge_r, eq_r;
  logic [63:0] off_r;
  logic        hit_r, fit_fail_r, prot_fail_r;
  logic [64:0] fit_end;
  logic        prot_fail;
  logic        take_add, take_nb;

  assign occ  = occ_r;
  assign base = base_r;
  assign size = size_r;
  assign perm = perm_r;

  // Priority chains: earlier cells win
  assign seen_hit_out  = seen_hit_in | hit_r;
  assign seen_eq_out   = seen_eq_in | eq_r;
  assign sts.first_hit = hit_r & ~seen_hit_in;
  assign sts.prot_fail = prot_fail_r;
  assign sts.fit_fail  = fit_fail_r;

  // Access fit and permission tests
  assign fit_end   = {1'b0, off_r} + {61'b0, acc_len};
  assign prot_fail = item_write ? (~perm_r[PERM_W] | perm_r[PERM_RO]) : ~perm_r[PERM_R];

  // First empty slot takes an added region; slots at or past a match shift
  assign take_add = ctl.add_en & ~occ_r & prev_occ;
  assign take_nb  = ctl.remove_en & seen_eq_out;

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (take_add) begin
      occ_r <= 1'b1;
    end else if (take_nb) begin
      occ_r <= nb_occ;
    end
  end

  // Region contents
  always_ff @(posedge clk) begin
    if (take_add) begin
      base_r <= item_addr;
      size_r <= item_len;
      perm_r <= item_flags;
    end else if (take_nb) begin
      base_r <= nb_base;
      size_r <= nb_size;
      perm_r <= nb_perm;
    end else if (ctl.isolate) begin
      perm_r <= perm_r & ~(4'b0001 << PERM_W) & ~(4'b0001 << PERM_X);
    end else if (ctl.read_only) begin
      perm_r <= 4'b0001 << PERM_R;
    end
  end

  // Stage one: offset and base match, taken from the incoming beat
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ge_r  <= cap_addr >= base_r;
      off_r <= cap_addr - base_r;
      eq_r  <= occ_r & (cap_addr == base_r);
    end
  end

  // Stage two: containment, fit and permission
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      hit_r       <= occ_r & ge_r & (off_r < size_r);
      fit_fail_r  <= fit_end > {1'b0, size_r};
      prot_fail_r <= prot_fail;
    end
  end

endmodule
